[sv/nearest_ray_sphere_hit_macros.svh]
// assertion macros for the nearest ray-sphere hit block
`ifndef NEAREST_RAY_SPHERE_HIT_MACROS_SVH
`define NEAREST_RAY_SPHERE_HIT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication, clocked on i_clk, held off during reset
`define NRSH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nrsh check failed");
// next-cycle implication
`define NRSH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nrsh check failed");
`else
`define NRSH_ASSERT_NOW(label, ante, cons)
`define NRSH_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[sv/nrsh_pkg.sv]
// shared constants for the nearest ray-sphere hit block
package nrsh_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int ACC_W  = 77;   // signed accumulator for dot and discriminant
    localparam int OC_W   = 33;   // origin minus centre
    localparam int B_W    = 37;   // b after floor shift
    localparam int ROOT_W = 38;
    localparam int REM_W  = 42;
    localparam int T_W    = 40;   // candidate distance
    localparam int DIR_FRAC = 14;

    // configuration register indexes
    localparam logic [2:0] REG_ORIGIN_X = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [2:0] REG_DIR_X    = 3'd3;
    localparam logic [2:0] REG_DIR_Y    = 3'd4;
    localparam logic [2:0] REG_DIR_Z    = 3'd5;

    typedef logic signed [ACC_W-1:0] t_acc;
endpackage

[sv/nearest_ray_sphere_hit.sv]
// nearest ray-sphere hit: serial intersection of one sphere per beat
//
// The ray (origin and unit direction) sits in six configuration registers.
// Each input beat carries one sphere. Spheres not visible, not spheres or
// incomplete are dropped. Every other sphere runs through one bit-serial
// shift-add multiplier into a 77-bit accumulator: three dot product terms,
// b squared, radius squared and three oc squared terms, each product set up
// in S_LOAD. S_CHK then checks the sign of the discriminant. A radix-2
// restoring square root follows, and S_DONE picks the near or far root and
// updates the best hit. A negative discriminant skips the root. The block
// takes one sphere at a time (o_stall is high while it works). On a beat
// marked last the result (hit, id, distance) goes to an output register
// that waits for the consumer. It is loaded from S_OUT, which waits while
// an earlier result is still stalled. The best hit is then cleared for the
// next scan.
// Configuration writes are always ready and must only occur while idle.
module nearest_ray_sphere_hit
    import nrsh_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    // sphere beats
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [31:0]         i_entity_id,
    input  logic signed [31:0]  i_center_x,
    input  logic signed [31:0]  i_center_y,
    input  logic signed [31:0]  i_center_z,
    input  logic [30:0]         i_sphere_radius,
    input  logic                i_visible,
    input  logic                i_is_sphere,
    input  logic                i_complete,
    input  logic                i_last,
    // result beats
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_hit,
    output logic [31:0]         o_target_id,
    output logic [31:0]         o_hit_distance
);
    `include "nearest_ray_sphere_hit_macros.svh"

    // epsilon in lsb: ceil(0.0001 * 2^FRAC_BITS)
    localparam longint EPS_INT = ((64'sd1 <<< FRAC_BITS) + 64'sd9999) / 64'sd10000;
    localparam logic signed [T_W-1:0] EPS = T_W'(EPS_INT);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_SQRT = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    localparam logic [2:0] OP_DOT_X  = 3'd0;
    localparam logic [2:0] OP_DOT_Y  = 3'd1;
    localparam logic [2:0] OP_DOT_Z  = 3'd2;
    localparam logic [2:0] OP_B_SQ   = 3'd3;
    localparam logic [2:0] OP_R_SQ   = 3'd4;
    localparam logic [2:0] OP_OCSQ_X = 3'd5;
    localparam logic [2:0] OP_OCSQ_Y = 3'd6;
    localparam logic [2:0] OP_OCSQ_Z = 3'd7;

    // configuration registers
    logic signed [31:0] r_org_x, r_org_y, r_org_z;
    logic signed [15:0] r_dir_x, r_dir_y, r_dir_z;

    // control
    logic [2:0]  r_state;
    logic [2:0]  r_op;
    logic [5:0]  r_cnt;
    logic        r_neg;
    logic        r_sgn_b;
    logic        r_last;
    logic        r_ovalid;

    // datapath
    logic [31:0]            r_id;
    logic [30:0]            r_rad;
    logic signed [OC_W-1:0] r_oc_x, r_oc_y, r_oc_z;
    logic signed [B_W-1:0]  r_b;
    t_acc                   r_acc;
    t_acc                   r_mcand;
    logic [ROOT_W-1:0]      r_mpl;
    logic [75:0]            r_radicand;
    logic [REM_W-1:0]       r_rem;
    logic [ROOT_W-1:0]      r_root;
    logic [31:0]            r_best_dist;
    logic [31:0]            r_best_id;
    logic [31:0]            r_out_id;
    logic [31:0]            r_out_dist;
    logic                   r_out_hit;

    logic take;
    logic out_free;
    assign take     = i_visible & i_is_sphere & i_complete;
    assign out_free = !r_ovalid || !i_stall;

    assign o_cfg_ready    = 1'b1;
    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_ovalid;
    assign o_hit          = r_out_hit;
    assign o_target_id    = r_out_id;
    assign o_hit_distance = r_out_dist;

    // magnitudes for the squaring products
    logic [OC_W-1:0] mag_x, mag_y, mag_z;
    logic [B_W-1:0]  mag_b;
    assign mag_x = r_oc_x[OC_W-1] ? OC_W'(-r_oc_x) : OC_W'(r_oc_x);
    assign mag_y = r_oc_y[OC_W-1] ? OC_W'(-r_oc_y) : OC_W'(r_oc_y);
    assign mag_z = r_oc_z[OC_W-1] ? OC_W'(-r_oc_z) : OC_W'(r_oc_z);
    assign mag_b = r_b[B_W-1] ? B_W'(-r_b) : B_W'(r_b);

    // operand select for the product about to start
    t_acc              op_a;
    logic [ROOT_W-1:0] op_b;
    logic [5:0]        op_n;
    logic              op_neg;
    logic              op_sgn;
    always_comb begin
        op_a   = '0;
        op_b   = '0;
        op_n   = 6'd0;
        op_neg = 1'b0;
        op_sgn = 1'b0;
        case (r_op)
            OP_DOT_X: begin
                op_a = ACC_W'(r_oc_x); op_b = ROOT_W'(r_dir_x); op_n = 6'd15; op_sgn = 1'b1;
            end
            OP_DOT_Y: begin
                op_a = ACC_W'(r_oc_y); op_b = ROOT_W'(r_dir_y); op_n = 6'd15; op_sgn = 1'b1;
            end
            OP_DOT_Z: begin
                op_a = ACC_W'(r_oc_z); op_b = ROOT_W'(r_dir_z); op_n = 6'd15; op_sgn = 1'b1;
            end
            OP_B_SQ: begin
                op_a = ACC_W'(mag_b); op_b = ROOT_W'(mag_b); op_n = 6'd36;
            end
            OP_R_SQ: begin
                op_a = ACC_W'(r_rad); op_b = ROOT_W'(r_rad); op_n = 6'd30;
            end
            OP_OCSQ_X: begin
                op_a = ACC_W'(mag_x); op_b = ROOT_W'(mag_x); op_n = 6'd32; op_neg = 1'b1;
            end
            OP_OCSQ_Y: begin
                op_a = ACC_W'(mag_y); op_b = ROOT_W'(mag_y); op_n = 6'd32; op_neg = 1'b1;
            end
            OP_OCSQ_Z: begin
                op_a = ACC_W'(mag_z); op_b = ROOT_W'(mag_z); op_n = 6'd32; op_neg = 1'b1;
            end
            default: begin
                op_a = '0;
            end
        endcase
    end

    // one shift-add step; the top bit of a signed multiplier weighs negative
    logic sub_now;
    t_acc mul_acc;
    assign sub_now = r_neg ^ (r_sgn_b && (r_cnt == 6'd0));
    assign mul_acc = !r_mpl[0] ? r_acc : (sub_now ? r_acc - r_mcand : r_acc + r_mcand);

    // one restoring root step: two radicand bits in, one root bit out
    logic [REM_W-1:0] rem2;
    logic [REM_W-1:0] trial;
    logic             fits;
    assign rem2  = {r_rem[REM_W-3:0], r_radicand[75:74]};
    assign trial = REM_W'({r_root, 2'b01});
    assign fits  = (rem2 >= trial);

    // root selection and distance clamp
    logic signed [T_W-1:0] neg_b, near_t, far_t, t_sel;
    logic                  t_ok;
    logic [31:0]           hit_dist;
    always_comb begin
        neg_b  = -T_W'(r_b);
        near_t = neg_b - $signed(T_W'(r_root));
        far_t  = neg_b + $signed(T_W'(r_root));
        t_ok   = 1'b1;
        t_sel  = near_t;
        if (near_t > EPS) begin
            t_sel = near_t;
        end else if (far_t > EPS) begin
            t_sel = far_t;
        end else begin
            t_ok = 1'b0;
        end
        hit_dist = (t_sel[T_W-1:32] != '0) ? 32'hFFFF_FFFF : t_sel[31:0];
    end

    logic r_disc_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x     <= '0;
            r_org_y     <= '0;
            r_org_z     <= '0;
            r_dir_x     <= 16'sd16384;
            r_dir_y     <= '0;
            r_dir_z     <= '0;
            r_state     <= S_IDLE;
            r_op        <= '0;
            r_cnt       <= '0;
            r_neg       <= 1'b0;
            r_sgn_b     <= 1'b0;
            r_last      <= 1'b0;
            r_ovalid    <= 1'b0;
            r_disc_ok   <= 1'b0;
            r_best_dist <= '1;
            r_best_id   <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_ORIGIN_X: r_org_x <= i_cfg_data;
                    REG_ORIGIN_Y: r_org_y <= i_cfg_data;
                    REG_ORIGIN_Z: r_org_z <= i_cfg_data;
                    REG_DIR_X:    r_dir_x <= i_cfg_data[15:0];
                    REG_DIR_Y:    r_dir_y <= i_cfg_data[15:0];
                    REG_DIR_Z:    r_dir_z <= i_cfg_data[15:0];
                    default: ;
                endcase
            end

            // a new result loaded in S_OUT keeps the valid high
            if (r_ovalid && !i_stall && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_last <= i_last;
                        r_id   <= i_entity_id;
                        r_rad  <= i_sphere_radius;
                        r_oc_x <= OC_W'(r_org_x) - OC_W'(i_center_x);
                        r_oc_y <= OC_W'(r_org_y) - OC_W'(i_center_y);
                        r_oc_z <= OC_W'(r_org_z) - OC_W'(i_center_z);
                        r_op   <= '0;
                        r_acc  <= '0;
                        if (take) begin
                            r_state <= S_LOAD;
                        end else if (i_last) begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_LOAD: begin
                    r_mcand <= op_a;
                    r_mpl   <= op_b;
                    r_cnt   <= op_n;
                    r_neg   <= op_neg;
                    r_sgn_b <= op_sgn;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    // the discriminant starts from zero once the dot product is done
                    r_acc   <= ((r_cnt == 6'd0) && (r_op == OP_DOT_Z)) ? '0 : mul_acc;
                    r_mcand <= r_mcand <<< 1;
                    r_mpl   <= r_mpl >> 1;
                    r_cnt   <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_op <= r_op + 3'd1;
                        if (r_op == OP_DOT_Z) begin
                            // floor shift of the dot product
                            r_b     <= mul_acc[DIR_FRAC+B_W-1:DIR_FRAC];
                            r_state <= S_LOAD;
                        end else if (r_op == OP_OCSQ_Z) begin
                            r_state <= S_CHK;
                        end else begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_CHK: begin
                    r_radicand <= r_acc[75:0];
                    r_rem      <= '0;
                    r_root     <= '0;
                    r_cnt      <= 6'(ROOT_W - 1);
                    r_disc_ok  <= !r_acc[ACC_W-1];
                    // negative discriminant: no hit for this sphere
                    r_state    <= r_acc[ACC_W-1] ? S_DONE : S_SQRT;
                end
                S_SQRT: begin
                    r_radicand <= r_radicand << 2;
                    r_rem      <= fits ? rem2 - trial : rem2;
                    r_root     <= {r_root[ROOT_W-2:0], fits};
                    r_cnt      <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // strictly closer hits replace the best
                    if (r_disc_ok && t_ok && (hit_dist < r_best_dist)) begin
                        r_best_dist <= hit_dist;
                        r_best_id   <= r_id;
                    end
                    r_state <= r_last ? S_OUT : S_IDLE;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ovalid    <= 1'b1;
                        r_out_hit   <= (r_best_id != '0);
                        r_out_id    <= r_best_id;
                        r_out_dist  <= (r_best_id != '0) ? r_best_dist : '0;
                        r_best_dist <= '1;
                        r_best_id   <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // a nonnegative discriminant always goes on to the root
    `NRSH_ASSERT_NEXT(a_chk_to_sqrt, (r_state == S_CHK) && !r_acc[ACC_W-1], r_state == S_SQRT)
    // a result beat clears the running best for the next scan
    `NRSH_ASSERT_NEXT(a_out_clears, (r_state == S_OUT) && out_free, o_valid && (r_best_id == '0) && (r_best_dist == '1))
    // a reported hit always names a nonzero entity
    `NRSH_ASSERT_NOW(a_hit_id, o_valid && o_hit, o_target_id != '0)

endmodule

[test/nearest_ray_sphere_hit_tb.sv]
// self-checking testbench for the nearest ray-sphere hit block
module nearest_ray_sphere_hit_tb;
    import nrsh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  FRAC      = FRAC_BITS_DEF;
    // epsilon in distance lsb: ceil(0.0001 * 2^FRAC)
    localparam longint EPS_LSB = ((longint'(1) << FRAC) + 9999) / 10000;
    localparam longint ONE     = longint'(1) << FRAC;
    // extra idle time at the end of a drain, long enough for one tested sphere in flight
    localparam int  DRAIN_CYCLES = 400;

    typedef struct packed {
        logic [31:0] entity_id;
        logic [31:0] center_x;
        logic [31:0] center_y;
        logic [31:0] center_z;
        logic [30:0] radius;
        logic        visible;
        logic        is_sphere;
        logic        complete;
        logic        last;
    } t_sphere;

    typedef struct packed {
        logic        hit;
        logic [31:0] target_id;
        logic [31:0] distance;
    } t_hit_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_entity_id;
    logic signed [31:0] i_center_x;
    logic signed [31:0] i_center_y;
    logic signed [31:0] i_center_z;
    logic [30:0] i_sphere_radius;
    logic        i_visible;
    logic        i_is_sphere;
    logic        i_complete;
    logic        i_last;
    logic        o_valid;
    logic        i_stall;
    logic        o_hit;
    logic [31:0] o_target_id;
    logic [31:0] o_hit_distance;

    nearest_ray_sphere_hit uut (.*);

    // shadow copy of the ray registers and the running best hit
    logic signed [31:0] ray_origin [3];
    logic signed [15:0] ray_dir [3];
    logic [31:0]        best_dist;
    logic [31:0]        best_id;

    t_hit_result pending_hits[$];

    int mismatches;
    int spheres_sent;
    int results_seen;
    int hits_seen;
    int send_gap_pct;
    int recv_stall_pct;

    // clock and timeout
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #80ms;
        $display("timeout waiting for results");
        $display("end of test: mismatches");
        $finish;
    end

    // ray-sphere intersection, returns -1 for no hit
    function automatic longint ray_hit_distance(logic signed [31:0] cx, logic signed [31:0] cy,
                                                logic signed [31:0] cz, logic [30:0] radius);
        longint      oc [3];
        longint      dot;
        longint      b;
        longint      near_t;
        longint      far_t;
        logic [127:0] mg;
        logic [127:0] ocsq;
        logic [127:0] lhs;
        logic [127:0] disc;
        logic [127:0] root;
        logic [127:0] cand;
        oc[0] = longint'(ray_origin[0]) - longint'(cx);
        oc[1] = longint'(ray_origin[1]) - longint'(cy);
        oc[2] = longint'(ray_origin[2]) - longint'(cz);
        dot  = 0;
        ocsq = '0;
        for (int k = 0; k < 3; k++) begin
            dot += oc[k] * longint'(ray_dir[k]);
            mg = 128'(oc[k] < 0 ? -oc[k] : oc[k]);
            ocsq += mg * mg;
        end
        // arithmetic shift rounds toward minus infinity
        b   = dot >>> DIR_FRAC;
        mg  = 128'(b < 0 ? -b : b);
        lhs = mg * mg + 128'(radius) * 128'(radius);
        if (ocsq > lhs)
            return -1;
        disc = lhs - ocsq;
        root = '0;
        for (int k = 40; k >= 0; k--) begin
            cand = root | (128'(1) << k);
            if (cand * cand <= disc)
                root = cand;
        end
        near_t = -b - longint'(root);
        far_t  = -b + longint'(root);
        if (near_t > EPS_LSB)
            return near_t;
        if (far_t > EPS_LSB)
            return far_t;
        return -1;
    endfunction

    // fold one accepted sphere into the running best hit
    task automatic track_nearest(t_sphere s);
        longint      t;
        logic [31:0] d;
        t_hit_result r;
        if (s.visible && s.is_sphere && s.complete) begin
            t = ray_hit_distance(s.center_x, s.center_y, s.center_z, s.radius);
            if (t >= 0) begin
                d = (t > longint'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : t[31:0];
                // strictly closer only, ties keep the first
                if (d < best_dist) begin
                    best_dist = d;
                    best_id   = s.entity_id;
                end
            end
        end
        if (s.last) begin
            r.hit       = (best_id != 0);
            r.target_id = best_id;
            r.distance  = r.hit ? best_dist : 32'd0;
            pending_hits.push_back(r);
            best_dist = 32'hFFFF_FFFF;
            best_id   = '0;
        end
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // result side: random stall, compare each beat with the oldest expectation
    always @(posedge i_clk) begin
        t_hit_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (pending_hits.size() == 0) begin
                    report_mismatch("unexpected result, id", o_target_id, 32'd0);
                end else begin
                    want = pending_hits.pop_front();
                    if (o_hit !== want.hit)
                        report_mismatch("hit", 32'(o_hit), 32'(want.hit));
                    if (o_target_id !== want.target_id)
                        report_mismatch("target_id", o_target_id, want.target_id);
                    if (o_hit_distance !== want.distance)
                        report_mismatch("hit_distance", o_hit_distance, want.distance);
                    if (want.hit)
                        hits_seen++;
                end
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // one sphere beat; entered and left just after a rising edge
    task automatic send_sphere(t_sphere s);
        i_valid         <= 1'b1;
        i_entity_id     <= s.entity_id;
        i_center_x      <= s.center_x;
        i_center_y      <= s.center_y;
        i_center_z      <= s.center_z;
        i_sphere_radius <= s.radius;
        i_visible       <= s.visible;
        i_is_sphere     <= s.is_sphere;
        i_complete      <= s.complete;
        i_last          <= s.last;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        track_nearest(s);
        spheres_sent++;
        if ($urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // drop valid and let the block finish everything in flight
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_hits.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] index, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (index)
            REG_ORIGIN_X: ray_origin[0] = data;
            REG_ORIGIN_Y: ray_origin[1] = data;
            REG_ORIGIN_Z: ray_origin[2] = data;
            REG_DIR_X:    ray_dir[0] = data[15:0];
            REG_DIR_Y:    ray_dir[1] = data[15:0];
            REG_DIR_Z:    ray_dir[2] = data[15:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // direction writes carry random upper bits, which must be dropped
    task automatic set_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                           logic [15:0] dx, logic [15:0] dy, logic [15:0] dz);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_ORIGIN_Z, oz);
        write_reg(REG_DIR_X, {16'($urandom), dx});
        write_reg(REG_DIR_Y, {16'($urandom), dy});
        write_reg(REG_DIR_Z, {16'($urandom), dz});
    endtask

    function automatic t_sphere make_sphere(logic [31:0] id, longint cx, longint cy,
                                            longint cz, longint r, int last);
        t_sphere s;
        s.entity_id = id;
        s.center_x  = cx[31:0];
        s.center_y  = cy[31:0];
        s.center_z  = cz[31:0];
        s.radius    = r[30:0];
        s.visible   = 1'b1;
        s.is_sphere = 1'b1;
        s.complete  = 1'b1;
        s.last      = (last != 0);
        return s;
    endfunction

    // ray along +x from the origin; each case closes its scan with a last beat
    task automatic test_basic_cases();
        t_sphere s;
        send_sphere(make_sphere(5, 10 * ONE, 0, 0, ONE, 1));       // plain front hit
        send_sphere(make_sphere(6, 10 * ONE, 5 * ONE, 0, ONE, 1)); // negative discriminant
        send_sphere(make_sphere(7, 0, 0, 0, 2 * ONE, 1));          // origin inside, far root
        send_sphere(make_sphere(8, -10 * ONE, 0, 0, ONE, 1));      // sphere behind the ray
        // near root sits exactly on epsilon, so the far one is taken
        send_sphere(make_sphere(9, ONE + EPS_LSB, 0, 0, ONE, 1));
        // tiny sphere at the origin: both roots at or under epsilon
        send_sphere(make_sphere(10, 0, 0, 0, 3, 1));
        // tie: the first of equal distances wins
        send_sphere(make_sphere(11, 20 * ONE, 0, 0, ONE, 0));
        send_sphere(make_sphere(12, 20 * ONE, 0, 0, ONE, 1));
        // id zero as the nearest hides the farther hit
        send_sphere(make_sphere(13, 30 * ONE, 0, 0, ONE, 0));
        send_sphere(make_sphere(0, 3 * ONE, 0, 0, ONE, 1));
        // each skip flag alone, then a skipped beat closing a scan
        s = make_sphere(14, 4 * ONE, 0, 0, ONE, 0);
        s.visible = 1'b0;
        send_sphere(s);
        s = make_sphere(15, 4 * ONE, 0, 0, ONE, 0);
        s.is_sphere = 1'b0;
        send_sphere(s);
        s = make_sphere(16, 4 * ONE, 0, 0, ONE, 0);
        s.complete = 1'b0;
        send_sphere(s);
        send_sphere(make_sphere(17, 8 * ONE, 0, 0, ONE, 0));
        s = make_sphere(18, 2 * ONE, 0, 0, ONE, 1);
        s.visible = 1'b0;
        send_sphere(s);
        drain();
    endtask

    // register and field extremes, distance saturation
    task automatic test_extremes();
        set_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'sd16384, 16'sd0, 16'sd0);
        // centre at the far end: distance just under 32 bits
        send_sphere(make_sphere(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                32'h8000_0000, ONE, 1));
        // origin just outside a maximal sphere: near root under epsilon, far root at 2^32 saturates, no hit
        send_sphere(make_sphere(32'hFFFF_FFFD, 1, 32'h8000_0000,
                                32'h8000_0000, 32'h7FFF_FFFF, 1));
        // huge radius still misses, the centre lies far off the ray
        send_sphere(make_sphere(32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 32'h7FFF_FFFF, 1));
        drain();
        set_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000, 16'hC000, 16'h7FFF);
        write_reg(3'd6, $urandom); // unused indexes are ignored
        write_reg(3'd7, $urandom);
        send_sphere(make_sphere(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h7FFF_FFFF, 0));
        send_sphere(make_sphere(2, 0, 0, 0, 0, 0));
        send_sphere(make_sphere(3, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h4000_0000, 1));
        drain();
        set_ray(0, 0, 0, -16'sd16384, 16'sd16384, -16'sd16384);
        send_sphere(make_sphere(4, -5 * ONE, 5 * ONE, -5 * ONE, 2 * ONE, 1));
        drain();
    endtask

    // random ray: mostly near the scene, sometimes anywhere
    task automatic pick_ray();
        logic [31:0] o [3];
        logic [15:0] d [3];
        int          axis;
        for (int k = 0; k < 3; k++)
            o[k] = ($urandom_range(3) == 0) ? $urandom
                                            : 32'(int'($urandom_range(0, 400)) - 200) << FRAC;
        axis = $urandom_range(2);
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(3))
                0: d[k] = 16'($urandom);
                1: d[k] = 16'(int'($urandom_range(0, 32768)) - 16384);
                default: d[k] = (k == axis) ? ($urandom_range(1) ? 16'sd16384 : -16'sd16384)
                                            : 16'(int'($urandom_range(0, 4000)) - 2000);
            endcase
        end
        set_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
    endtask

    // mostly spheres placed along the ray, the rest raw noise
    function automatic t_sphere random_sphere(logic last, ref longint prev_t);
        t_sphere s;
        longint  t;
        longint  c [3];
        if ($urandom_range(99) < 20) begin
            s = t_sphere'({$urandom, $urandom, $urandom, $urandom, $urandom, 3'($urandom)});
            s.visible   = $urandom_range(3) != 0;
            s.is_sphere = $urandom_range(3) != 0;
            s.complete  = $urandom_range(3) != 0;
        end else begin
            // reuse the previous distance now and then for ties
            t = ($urandom_range(7) == 0) ? prev_t
                                         : longint'($urandom_range(0, 300)) * ONE
                                           + longint'($urandom_range(0, 65535));
            prev_t = t;
            for (int k = 0; k < 3; k++)
                c[k] = longint'(ray_origin[k]) + ((longint'(ray_dir[k]) * t) >>> DIR_FRAC)
                       + longint'(int'($urandom_range(0, 2 * 65536)) - 65536);
            s = make_sphere(($urandom_range(15) == 0) ? 32'd0 : $urandom, c[0], c[1], c[2],
                            longint'($urandom_range(0, 6 * 65536)), 0);
            if ($urandom_range(19) == 0)
                s.visible = 1'b0;
        end
        s.last = last;
        return s;
    endfunction

    task automatic test_random_scans(int count, int gap_pct, int stall_pct);
        int     sent;
        int     scan_len;
        longint prev_t;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        sent   = 0;
        prev_t = 10 * ONE;
        while (sent < count) begin
            if ($urandom_range(3) == 0) begin
                drain();
                pick_ray();
            end
            scan_len = $urandom_range(1, 12);
            for (int k = 0; k < scan_len; k++)
                send_sphere(random_sphere(k == scan_len - 1, prev_t));
            sent += scan_len;
        end
        drain();
    endtask

    initial begin
        mismatches     = 0;
        spheres_sent   = 0;
        results_seen   = 0;
        hits_seen      = 0;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        ray_origin[0] = '0;
        ray_origin[1] = '0;
        ray_origin[2] = '0;
        ray_dir[0] = 16'sd16384;
        ray_dir[1] = '0;
        ray_dir[2] = '0;
        best_dist = 32'hFFFF_FFFF;
        best_id   = '0;
        i_rst_n         <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= '0;
        i_cfg_data      <= '0;
        i_valid         <= 1'b0;
        i_entity_id     <= '0;
        i_center_x      <= '0;
        i_center_y      <= '0;
        i_center_z      <= '0;
        i_sphere_radius <= '0;
        i_visible       <= 1'b0;
        i_is_sphere     <= 1'b0;
        i_complete      <= 1'b0;
        i_last          <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset ray first, so the default registers are exercised
        test_basic_cases();
        test_extremes();
        test_random_scans(470, 0, 0);
        test_random_scans(470, 58, 0);
        test_random_scans(470, 0, 58);
        test_random_scans(470, 7, 7);

        $display("spheres sent %0d, scan results checked %0d with %0d hits",
                 spheres_sent, results_seen, hits_seen);
        $display("covered skip flags, misses, far-root picks, ties, id zero, saturation");
        if (mismatches == 0 && pending_hits.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule
